>>> rtl/psh_pkg.sv
// Shared types, constants and the arctangent table for the pursuit heading/speed block.
package psh_pkg;

   localparam int CordicSteps = 16;
   localparam int StepBits    = 5;

   typedef enum logic [2:0] {
      CSR_TICK_LENGTH     = 3'd0,
      CSR_TURN_GAIN       = 3'd1,
      CSR_ACCEL_GAIN      = 3'd2,
      CSR_DECEL_GAIN      = 3'd3,
      CSR_SPEED_LIMIT     = 3'd4,
      CSR_ALIGN_THRESHOLD = 3'd5
   } csr_index_type;

   typedef enum logic {
      MODE_VECTOR = 1'b0,
      MODE_ROTATE = 1'b1
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_cmd_type;

   typedef struct packed {
      logic [15:0] tick_length;
      logic [11:0] turn_gain;
      logic [15:0] accel_gain;
      logic [15:0] decel_gain;
      logic [16:0] speed_limit;
      logic [14:0] align_threshold;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VEC,
      ST_ERR,
      ST_TURN,
      ST_HEAD,
      ST_ACC,
      ST_VMUL,
      ST_SPD,
      ST_DIST,
      ST_ROT,
      ST_XMUL,
      ST_PX,
      ST_PY,
      ST_DONE
   } state_type;

   // Arctangent of 2^-i with 2^32 units per turn.
   function automatic logic [31:0] atan_lookup(input logic [StepBits-1:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/psh_csr.sv
// Configuration register file behind the APB-style port.
module psh_csr import psh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;
   logic          wr;

   assign idx        = csr_index_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            CSR_TICK_LENGTH:     cfg_in.tick_length     = csr_pwdata[15:0];
            CSR_TURN_GAIN:       cfg_in.turn_gain       = csr_pwdata[11:0];
            CSR_ACCEL_GAIN:      cfg_in.accel_gain      = csr_pwdata[15:0];
            CSR_DECEL_GAIN:      cfg_in.decel_gain      = csr_pwdata[15:0];
            CSR_SPEED_LIMIT:     cfg_in.speed_limit     = csr_pwdata[16:0];
            CSR_ALIGN_THRESHOLD: cfg_in.align_threshold = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_TICK_LENGTH:     csr_prdata = {16'd0, cfg_ff.tick_length};
         CSR_TURN_GAIN:       csr_prdata = {20'd0, cfg_ff.turn_gain};
         CSR_ACCEL_GAIN:      csr_prdata = {16'd0, cfg_ff.accel_gain};
         CSR_DECEL_GAIN:      csr_prdata = {16'd0, cfg_ff.decel_gain};
         CSR_SPEED_LIMIT:     csr_prdata = {15'd0, cfg_ff.speed_limit};
         CSR_ALIGN_THRESHOLD: csr_prdata = {17'd0, cfg_ff.align_threshold};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_length     <= 16'd1311;
         cfg_ff.turn_gain       <= 12'd1280;
         cfg_ff.accel_gain      <= 16'd5120;
         cfg_ff.decel_gain      <= 16'd3840;
         cfg_ff.speed_limit     <= 17'd76800;
         cfg_ff.align_threshold <= 15'd910;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/psh_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, shared by vectoring and rotation.
module psh_cordic import psh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cordic_cmd_type      cmd,
   input  logic signed [33:0]  x0,
   input  logic signed [33:0]  y0,
   input  logic signed [32:0]  z0,
   output logic                busy,
   output logic signed [33:0]  x_out,
   output logic signed [33:0]  y_out,
   output logic signed [32:0]  z_out
);

   logic signed [33:0]  x_ff, y_ff, x_in, y_in;
   logic signed [32:0]  z_ff, z_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                busy_ff, busy_in;
   cordic_mode_type     mode_ff, mode_in;
   logic                up;
   logic signed [33:0]  xs, ys;
   logic signed [32:0]  angle;

   always_comb begin
      xs    = x_ff >>> step_ff;
      ys    = y_ff >>> step_ff;
      angle = $signed({1'b0, atan_lookup(step_ff)});
      // Both modes turn the same way whenever the steering sign says "turn up".
      if (mode_ff == MODE_VECTOR) up = !(y_ff > 0);
      else                        up = !z_ff[32];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;
      if (cmd.start) begin
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
         step_in = '0;
         busy_in = 1'b1;
         mode_in = cmd.mode;
      end else if (busy_ff) begin
         if (up) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + angle;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepBits'(CordicSteps - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      mode_ff <= mode_in;
   end

   assign busy  = busy_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

>>> rtl/pursuit_heading_speed_step.sv
// Pursuit vehicle step: one tick per input transfer. Each tick runs two CORDIC passes that each
// hold the sequencer for 16 micro-rotations through the shared CORDIC unit plus a hand-over
// step, seven products through one shared multiplier with a register after it, and a return to
// idle to take the next transfer. The input is stalled while a tick is in progress; a finished
// result waits in the output register while the next tick is accepted, and a tick only completes
// once that register is free.
module pursuit_heading_speed_step import psh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [12:0] req_target_x,
   input  logic signed [12:0] req_target_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [21:0] rsp_pos_x,
   output logic signed [21:0] rsp_pos_y,
   output logic [16:0]        rsp_speed_out,
   output logic [15:0]        rsp_heading_out,
   output logic signed [16:0] rsp_accel_out,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cfg_type            cfg;
   state_type          state_ff, state_in;
   cordic_cmd_type     cmd;
   logic signed [33:0] cx0, cy0, cx, cy;
   logic signed [32:0] cz0, cz;
   logic               cbusy;

   logic signed [21:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [16:0]        speed_ff, speed_in;
   logic [15:0]        head_ff, head_in;
   logic signed [16:0] acc_ff, acc_in;
   logic signed [15:0] err_ff, err_in;
   logic               zero_ff, zero_in, flip_ff, flip_in, up_ff, up_in;
   logic [24:0]        dist_ff, dist_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic signed [61:0] prod_ff, prod_in;
   logic signed [32:0] mul_a;
   logic signed [28:0] mul_b;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [21:0] out_px_ff, out_px_in, out_py_ff, out_py_in;
   logic [16:0]        out_spd_ff, out_spd_in;
   logic [15:0]        out_head_ff, out_head_in;
   logic signed [16:0] out_acc_ff, out_acc_in;

   logic               accept;
   logic signed [23:0] dx, dy;
   logic [31:0]        zr;
   logic [15:0]        bearing;
   logic signed [16:0] mag;
   logic signed [61:0] rnd_t;
   logic signed [18:0] acc_sum;
   logic signed [19:0] spd_sum;
   logic signed [24:0] pos_sum;
   logic [15:0]        rot_hi;
   logic               rot_flip;
   logic [31:0]        zu;

   psh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   psh_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .x0    (cx0),
      .y0    (cy0),
      .z0    (cz0),
      .busy  (cbusy),
      .x_out (cx),
      .y_out (cy),
      .z_out (cz)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign dx = {{3{req_target_x[12]}}, req_target_x, 8'd0} - {{2{posx_ff[21]}}, posx_ff};
   assign dy = {{3{req_target_y[12]}}, req_target_y, 8'd0} - {{2{posy_ff[21]}}, posy_ff};
   assign zr = cz[31:0] + 32'h0000_8000;
   assign bearing = zero_ff ? 16'd0 : zr[31:16];
   assign mag = err_ff[15] ? -{err_ff[15], err_ff} : {err_ff[15], err_ff};
   assign rot_hi   = head_ff;
   assign rot_flip = (head_ff >= 16'h4000) && (head_ff < 16'hC000);
   assign zu       = {rot_hi, 16'd0} - (rot_flip ? 32'h8000_0000 : 32'd0);

   always_comb begin
      state_in     = state_ff;
      cmd.start    = 1'b0;
      cmd.mode     = MODE_VECTOR;
      cx0          = dx[23] ? -{{10{dx[23]}}, dx} : {{10{dx[23]}}, dx};
      cy0          = dx[23] ? -{{10{dy[23]}}, dy} : {{10{dy[23]}}, dy};
      cz0          = dx[23] ? 33'h0_8000_0000 : 33'd0;
      mul_a        = '0;
      mul_b        = '0;
      rnd_t        = '0;
      acc_sum      = '0;
      spd_sum      = '0;
      pos_sum      = '0;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      speed_in     = speed_ff;
      head_in      = head_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      zero_in      = zero_ff;
      flip_in      = flip_ff;
      up_in        = up_ff;
      dist_in      = dist_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_px_in    = out_px_ff;
      out_py_in    = out_py_ff;
      out_spd_in   = out_spd_ff;
      out_head_in  = out_head_ff;
      out_acc_in   = out_acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               zero_in   = (dx == 24'sd0) && (dy == 24'sd0);
               state_in  = ST_VEC;
            end
         end
         ST_VEC: begin
            if (!cbusy) state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in   = $signed(bearing - head_ff);
            mul_a    = $signed({17'd0, cfg.tick_length});
            mul_b    = $signed({17'd0, cfg.turn_gain});
            state_in = ST_TURN;
         end
         ST_TURN: begin
            mul_a    = {{17{err_ff[15]}}, err_ff};
            mul_b    = $signed({1'b0, prod_ff[27:0]});
            up_in    = (mag < $signed({2'b00, cfg.align_threshold}));
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            rnd_t    = prod_ff + 62'sd8388608;
            head_in  = head_ff + rnd_t[39:24];
            mul_a    = $signed({17'd0, up_ff ? cfg.accel_gain : cfg.decel_gain});
            mul_b    = $signed({13'd0, cfg.tick_length});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            rnd_t = prod_ff + 62'sd32768;
            if (up_ff) acc_sum = {{2{acc_ff[16]}}, acc_ff} + $signed({2'b00, rnd_t[32:16]});
            else       acc_sum = {{2{acc_ff[16]}}, acc_ff} - $signed({2'b00, rnd_t[32:16]});
            priority if (acc_sum > $signed({3'b000, cfg.accel_gain}))
               acc_in = $signed({1'b0, cfg.accel_gain});
            else if (acc_sum < -$signed({3'b000, cfg.decel_gain}))
               acc_in = -$signed({1'b0, cfg.decel_gain});
            else
               acc_in = acc_sum[16:0];
            state_in = ST_VMUL;
         end
         ST_VMUL: begin
            mul_a    = {{16{acc_ff[16]}}, acc_ff};
            mul_b    = $signed({13'd0, cfg.tick_length});
            state_in = ST_SPD;
         end
         ST_SPD: begin
            rnd_t   = prod_ff + 62'sd32768;
            spd_sum = $signed({3'b000, speed_ff}) + rnd_t[35:16];
            priority if (spd_sum < 20'sd0)
               speed_in = 17'd0;
            else if (spd_sum > $signed({3'b000, cfg.speed_limit}))
               speed_in = cfg.speed_limit;
            else
               speed_in = spd_sum[16:0];
            state_in = ST_DIST;
         end
         ST_DIST: begin
            mul_a     = $signed({16'd0, speed_ff});
            mul_b     = $signed({13'd0, cfg.tick_length});
            cmd.start = 1'b1;
            cmd.mode  = MODE_ROTATE;
            cx0       = 34'sh0_26DD_3B6A;
            cy0       = '0;
            cz0       = {zu[31], zu};
            flip_in   = rot_flip;
            state_in  = ST_ROT;
         end
         ST_ROT: begin
            // The speed product is held so the travel distance stays valid for the whole pass.
            mul_a   = $signed({16'd0, speed_ff});
            mul_b   = $signed({13'd0, cfg.tick_length});
            rnd_t   = prod_ff + 62'sd128;
            dist_in = rnd_t[32:8];
            if (!cbusy) begin
               c_in     = flip_ff ? -cx : cx;
               s_in     = flip_ff ? -cy : cy;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            mul_a    = c_ff[32:0];
            mul_b    = $signed({4'd0, dist_ff});
            state_in = ST_PX;
         end
         ST_PX: begin
            rnd_t   = prod_ff + 62'sh20_0000_0000;
            pos_sum = {{3{posx_ff[21]}}, posx_ff} + {rnd_t[61], rnd_t[61:38]};
            priority if (pos_sum > 25'sd2097151)       posx_in = 22'sh1F_FFFF;
            else if (pos_sum < -25'sd2097152)          posx_in = 22'sh20_0000;
            else                                       posx_in = pos_sum[21:0];
            mul_a    = s_ff[32:0];
            mul_b    = $signed({4'd0, dist_ff});
            state_in = ST_PY;
         end
         ST_PY: begin
            rnd_t   = prod_ff + 62'sh20_0000_0000;
            pos_sum = {{3{posy_ff[21]}}, posy_ff} + {rnd_t[61], rnd_t[61:38]};
            priority if (pos_sum > 25'sd2097151)       posy_in = 22'sh1F_FFFF;
            else if (pos_sum < -25'sd2097152)          posy_in = 22'sh20_0000;
            else                                       posy_in = pos_sum[21:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The result is loaded only once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_px_in    = posx_ff;
               out_py_in    = posy_ff;
               out_spd_in   = speed_ff;
               out_head_in  = head_ff;
               out_acc_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         posx_ff      <= '0;
         posy_ff      <= '0;
         speed_ff     <= 17'd12800;
         head_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         speed_ff     <= speed_in;
         head_ff      <= head_in;
         acc_ff       <= acc_in;
      end
      err_ff      <= err_in;
      zero_ff     <= zero_in;
      flip_ff     <= flip_in;
      up_ff       <= up_in;
      dist_ff     <= dist_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      out_px_ff   <= out_px_in;
      out_py_ff   <= out_py_in;
      out_spd_ff  <= out_spd_in;
      out_head_ff <= out_head_in;
      out_acc_ff  <= out_acc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = out_px_ff;
   assign rsp_pos_y       = out_py_ff;
   assign rsp_speed_out   = out_spd_ff;
   assign rsp_heading_out = out_head_ff;
   assign rsp_accel_out   = out_acc_ff;

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_VEC && cbusy))
      else $error("accepted transfer did not start the vectoring pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DONE))
      else $error("result appeared outside the completion step");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !cbusy)
      else $error("CORDIC unit restarted while busy");
`endif

endmodule
